// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked by clock, off while reset is high.
`define CJT_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cjtg assertion failed");

// Next-cycle implication, clocked by clock, off while reset is high.
`define CJT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cjtg assertion failed");

`endif

// ===== hdl/cjtg_pkg.sv =====
// ----------------------------------------------------------------------------
// cjtg_pkg
// Constants and types of the cubic joint trajectory generator.
// ----------------------------------------------------------------------------
package cjtg_pkg;

   localparam int JOINT_COUNT_DEF      = 2;
   localparam int FRAC_BITS_DEF        = 16;
   localparam int POINT_COUNT_BITS_DEF = 16;
   localparam int JMAX                 = 2;

   localparam logic [16:0] SAMPLE_INTERVAL_RST = 17'd655;
   localparam logic [30:0] MAX_JOINT_RATE_RST  = 31'd5898240;

   typedef enum logic [0:0] {
      REG_SAMPLE_INTERVAL = 1'b0,
      REG_MAX_JOINT_RATE  = 1'b1
   } csr_reg_type;

   typedef enum logic [18:0] {
      ST_IDLE = 19'h00001,
      ST_DUR  = 19'h00002,
      ST_CNT  = 19'h00004,
      ST_TC   = 19'h00008,
      ST_TP   = 19'h00010,
      ST_SDIV = 19'h00020,
      ST_SQ   = 19'h00040,
      ST_CU   = 19'h00080,
      ST_P    = 19'h00100,
      ST_OFF  = 19'h00200,
      ST_G    = 19'h00400,
      ST_VM   = 19'h00800,
      ST_VL   = 19'h01000,
      ST_VD   = 19'h02000,
      ST_HM   = 19'h04000,
      ST_YL   = 19'h08000,
      ST_YD   = 19'h10000,
      ST_AD   = 19'h20000,
      ST_OUT  = 19'h40000
   } state_type;

endpackage

// ===== hdl/cubic_joint_trajectory_generator.sv =====
// ----------------------------------------------------------------------------
// cubic_joint_trajectory_generator
// Two-joint cubic point-to-point planner with a shared multiplier and a
// bit-serial 64-step divider under one sequencer.
// ----------------------------------------------------------------------------
// Start request: two divisions (duration, then point count), one when the move is short.
// Tick request: up to seven divisions with two joints, one fewer per joint whose
// acceleration saturates. One request at a time; a result waits in its register.
// An idle tick is accepted and gives no result.
// Synchronous active-high reset: idle, no move, registers at reset values.
module cubic_joint_trajectory_generator #(
   parameter int JOINT_COUNT      = cjtg_pkg::JOINT_COUNT_DEF,
   parameter int FRAC_BITS        = cjtg_pkg::FRAC_BITS_DEF,
   parameter int POINT_COUNT_BITS = cjtg_pkg::POINT_COUNT_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // start_angle_0, start_angle_1, target_angle_0, target_angle_1, start_time
   input  logic [159:0] req_tdata,
   // mode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // angle_0, angle_1, velocity_0, velocity_1, accel_0, accel_1,
   // point_time, step_time
   output logic [255:0] rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int JM  = cjtg_pkg::JMAX;
   localparam int PCB = POINT_COUNT_BITS;
   localparam logic [PCB-1:0] CMAX = {PCB{1'b1}};
   localparam logic [63:0] THR  = (64'd1 << FRAC_BITS) / 64'd1000;
   localparam logic [63:0] M32  = 64'hFFFF_FFFF;
   localparam logic [63:0] YLIM = 64'd1 << (63 - FRAC_BITS);
   localparam logic [32:0] ONE31 = 33'h0_8000_0000;

   function automatic logic [31:0] sat_out(input logic [63:0] mag, input logic neg);
      logic [31:0] m;
      m = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      return neg ? (32'd0 - m) : m;
   endfunction

   cjtg_pkg::state_type state_ff, state_in;

   logic [16:0]          iv_ff, iv_in;
   logic [30:0]          rate_ff, rate_in;
   logic [31:0]          sang_ff [JM];
   logic [31:0]          sang_in [JM];
   logic signed [32:0]   dl_ff [JM];
   logic signed [32:0]   dl_in [JM];
   logic [31:0]          dur_ff, dur_in;
   logic [31:0]          t0_ff, t0_in;
   logic [PCB-1:0]       pidx_ff, pidx_in;
   logic [PCB-1:0]       ptot_ff, ptot_in;
   logic                 moving_ff, moving_in;

   logic [31:0]          tc_ff, tc_in;
   logic [31:0]          step_ff, step_in;
   logic [31:0]          s_ff, s_in;
   logic [31:0]          sq_ff, sq_in;
   logic [31:0]          cu_ff, cu_in;
   logic [31:0]          p_ff, p_in;
   logic [32:0]          mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic                 hneg_ff, hneg_in;
   logic [63:0]          tmp_ff, tmp_in;
   logic [0:0]           jsel_ff, jsel_in;
   logic [31:0]          ang_ff [JM];
   logic [31:0]          ang_in [JM];
   logic [31:0]          vel_ff [JM];
   logic [31:0]          vel_in [JM];
   logic [31:0]          acc_ff [JM];
   logic [31:0]          acc_in [JM];

   logic [63:0]          dq_ff, dq_in;
   logic [63:0]          dr_ff, dr_in;
   logic [63:0]          dd_ff, dd_in;
   logic [5:0]           dcnt_ff, dcnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [255:0]         rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [16:0]          iv_eff;
   logic [30:0]          rate_eff;
   logic [PCB-1:0]       idx;
   logic [32:0]          mul_a, mul_b;
   logic [65:0]          mul_p;
   logic [31:0]          tmin;
   logic [64:0]          rsh;
   logic                 dge;
   logic [64:0]          rnew;
   logic [63:0]          div_q;
   logic                 div_last;
   logic                 div_act;
   logic [31:0]          st_c [JM];
   logic [31:0]          tg_c [JM];
   logic signed [32:0]   dl_c [JM];
   logic [32:0]          mg_c [JM];
   logic [32:0]          maxmag_c;
   logic [34:0]          pv;
   logic [32:0]          s2x;
   logic [32:0]          hm;
   logic                 hneg_c;
   logic [33:0]          sa;
   logic [33:0]          angr;
   logic [63:0]          x6;
   logic [63:0]          durv;
   logic [64:0]          cntv;

   assign iv_eff   = (iv_ff == '0) ? 17'd1 : iv_ff;
   assign rate_eff = (rate_ff == '0) ? 31'd1 : rate_ff;
   assign idx      = pidx_ff + 1'b1;

   assign req_tready = (state_ff == cjtg_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      maxmag_c = '0;
      for (int j = 0; j < JM; j++) begin
         st_c[j] = req_tdata[32*j +: 32];
         tg_c[j] = req_tdata[64 + 32*j +: 32];
         if (j < JOINT_COUNT) begin
            dl_c[j] = $signed({tg_c[j][31], tg_c[j]}) - $signed({st_c[j][31], st_c[j]});
         end else begin
            dl_c[j] = '0;
         end
         mg_c[j] = dl_c[j][32] ? 33'(-dl_c[j]) : 33'(dl_c[j]);
         if (mg_c[j] > maxmag_c) begin
            maxmag_c = mg_c[j];
         end
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         cjtg_pkg::ST_TC: begin
            mul_a = 33'(idx);
            mul_b = 33'(iv_eff);
         end
         cjtg_pkg::ST_TP: begin
            mul_a = 33'(pidx_ff);
            mul_b = 33'(iv_eff);
         end
         cjtg_pkg::ST_SQ: begin
            mul_a = 33'(s_ff);
            mul_b = 33'(s_ff);
         end
         cjtg_pkg::ST_CU: begin
            mul_a = 33'(sq_ff);
            mul_b = 33'(s_ff);
         end
         cjtg_pkg::ST_OFF: begin
            mul_a = mag_ff;
            mul_b = 33'(p_ff);
         end
         cjtg_pkg::ST_G: begin
            mul_a = 33'(s_ff);
            mul_b = ONE31 - 33'(s_ff);
         end
         cjtg_pkg::ST_VM: begin
            mul_a = mag_ff;
            mul_b = tmp_ff[32:0];
         end
         cjtg_pkg::ST_HM: begin
            mul_a = mag_ff;
            mul_b = hm;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign tmin  = (mul_p > 66'(dur_ff)) ? dur_ff : mul_p[31:0];

   assign rsh      = {dr_ff, dq_ff[63]};
   assign dge      = rsh >= {1'b0, dd_ff};
   assign rnew     = dge ? (rsh - {1'b0, dd_ff}) : rsh;
   assign div_q    = {dq_ff[62:0], dge};
   assign div_last = (dcnt_ff == 6'd63);
   assign div_act  = (state_ff == cjtg_pkg::ST_DUR) || (state_ff == cjtg_pkg::ST_CNT)
                  || (state_ff == cjtg_pkg::ST_SDIV) || (state_ff == cjtg_pkg::ST_VD)
                  || (state_ff == cjtg_pkg::ST_YD) || (state_ff == cjtg_pkg::ST_AD);

   assign pv     = 35'(sq_ff) + (35'(sq_ff) << 1) - (35'(cu_ff) << 1);
   assign s2x    = {s_ff, 1'b0};
   assign hneg_c = s2x > ONE31;
   assign hm     = hneg_c ? (s2x - ONE31) : (ONE31 - s2x);
   assign sa     = {{2{sang_ff[jsel_ff][31]}}, sang_ff[jsel_ff]};
   assign angr   = neg_ff ? (sa - mul_p[64:31]) : (sa + mul_p[64:31]);
   assign x6     = (tmp_ff << 2) + (tmp_ff << 1);
   assign durv   = (div_q > M32) ? M32 : div_q;
   assign cntv   = 65'(div_q) + 65'd1;

   always_comb begin
      state_in     = state_ff;
      iv_in        = iv_ff;
      rate_in      = rate_ff;
      sang_in      = sang_ff;
      dl_in        = dl_ff;
      dur_in       = dur_ff;
      t0_in        = t0_ff;
      pidx_in      = pidx_ff;
      ptot_in      = ptot_ff;
      moving_in    = moving_ff;
      tc_in        = tc_ff;
      step_in      = step_ff;
      s_in         = s_ff;
      sq_in        = sq_ff;
      cu_in        = cu_ff;
      p_in         = p_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      hneg_in      = hneg_ff;
      tmp_in       = tmp_ff;
      jsel_in      = jsel_ff;
      ang_in       = ang_ff;
      vel_in       = vel_ff;
      acc_in       = acc_ff;
      dq_in        = dq_ff;
      dr_in        = dr_ff;
      dd_in        = dd_ff;
      dcnt_in      = dcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (cjtg_pkg::csr_reg_type'(csr_index))
            cjtg_pkg::REG_SAMPLE_INTERVAL: iv_in   = csr_data[16:0];
            cjtg_pkg::REG_MAX_JOINT_RATE:  rate_in = csr_data[30:0];
            default: iv_in = iv_ff;
         endcase
      end

      if (div_act) begin
         dq_in   = div_q;
         dr_in   = rnew[63:0];
         dcnt_in = dcnt_ff + 6'd1;
      end

      unique case (state_ff)
         cjtg_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (!req_tuser) begin
                  for (int j = 0; j < JM; j++) begin
                     sang_in[j] = (j < JOINT_COUNT) ? st_c[j] : 32'd0;
                     dl_in[j]   = dl_c[j];
                  end
                  t0_in     = req_tdata[159:128];
                  pidx_in   = '0;
                  moving_in = 1'b0;
                  dq_in     = 64'(maxmag_c) << FRAC_BITS;
                  dd_in     = 64'(rate_eff);
                  dr_in     = '0;
                  dcnt_in   = '0;
                  state_in  = cjtg_pkg::ST_DUR;
               end else if (moving_ff) begin
                  state_in = cjtg_pkg::ST_TC;
               end
            end
         end
         cjtg_pkg::ST_DUR: begin
            if (div_last) begin
               dur_in = durv[31:0];
               if (durv <= THR) begin
                  moving_in = 1'b0;
                  ptot_in   = '0;
                  state_in  = cjtg_pkg::ST_IDLE;
               end else begin
                  dq_in    = durv;
                  dd_in    = 64'(iv_eff);
                  dr_in    = '0;
                  dcnt_in  = '0;
                  state_in = cjtg_pkg::ST_CNT;
               end
            end
         end
         cjtg_pkg::ST_CNT: begin
            if (div_last) begin
               ptot_in   = (cntv > 65'(CMAX)) ? CMAX : cntv[PCB-1:0];
               moving_in = 1'b1;
               state_in  = cjtg_pkg::ST_IDLE;
            end
         end
         cjtg_pkg::ST_TC: begin
            tc_in    = tmin;
            state_in = cjtg_pkg::ST_TP;
         end
         cjtg_pkg::ST_TP: begin
            step_in = tc_ff - tmin;
            dq_in   = 64'(tc_ff) << 31;
            dd_in   = 64'(dur_ff);
            dr_in   = '0;
            dcnt_in = '0;
            jsel_in = 1'b0;
            for (int j = 0; j < JM; j++) begin
               ang_in[j] = '0;
               vel_in[j] = '0;
               acc_in[j] = '0;
            end
            state_in = cjtg_pkg::ST_SDIV;
         end
         cjtg_pkg::ST_SDIV: begin
            if (div_last) begin
               s_in     = div_q[31:0];
               state_in = cjtg_pkg::ST_SQ;
            end
         end
         cjtg_pkg::ST_SQ: begin
            sq_in    = mul_p[62:31];
            state_in = cjtg_pkg::ST_CU;
         end
         cjtg_pkg::ST_CU: begin
            cu_in    = mul_p[62:31];
            state_in = cjtg_pkg::ST_P;
         end
         cjtg_pkg::ST_P: begin
            p_in     = (pv > 35'(ONE31)) ? ONE31[31:0] : pv[31:0];
            neg_in   = dl_ff[jsel_ff][32];
            mag_in   = dl_ff[jsel_ff][32] ? 33'(-dl_ff[jsel_ff]) : 33'(dl_ff[jsel_ff]);
            state_in = cjtg_pkg::ST_OFF;
         end
         cjtg_pkg::ST_OFF: begin
            ang_in[jsel_ff] = angr[31:0];
            state_in        = cjtg_pkg::ST_G;
         end
         cjtg_pkg::ST_G: begin
            tmp_in   = 64'(mul_p[62:31]);
            state_in = cjtg_pkg::ST_VM;
         end
         cjtg_pkg::ST_VM: begin
            tmp_in   = mul_p[63:0];
            state_in = cjtg_pkg::ST_VL;
         end
         cjtg_pkg::ST_VL: begin
            dq_in    = x6;
            dd_in    = 64'(dur_ff) << (31 - FRAC_BITS);
            dr_in    = '0;
            dcnt_in  = '0;
            state_in = cjtg_pkg::ST_VD;
         end
         cjtg_pkg::ST_VD: begin
            if (div_last) begin
               vel_in[jsel_ff] = sat_out(div_q, neg_ff);
               state_in        = cjtg_pkg::ST_HM;
            end
         end
         cjtg_pkg::ST_HM: begin
            tmp_in   = 64'(mul_p[65:31]);
            hneg_in  = hneg_c;
            state_in = cjtg_pkg::ST_YL;
         end
         cjtg_pkg::ST_YL: begin
            dq_in    = x6 << FRAC_BITS;
            dd_in    = 64'(dur_ff);
            dr_in    = '0;
            dcnt_in  = '0;
            state_in = cjtg_pkg::ST_YD;
         end
         cjtg_pkg::ST_YD: begin
            if (div_last) begin
               if (div_q >= YLIM) begin
                  acc_in[jsel_ff] = sat_out(64'h7FFF_FFFF, neg_ff ^ hneg_ff);
                  if (jsel_ff == 1'b0 && JOINT_COUNT > 1) begin
                     jsel_in  = 1'b1;
                     state_in = cjtg_pkg::ST_P;
                  end else begin
                     state_in = cjtg_pkg::ST_OUT;
                  end
               end else begin
                  dq_in    = div_q << FRAC_BITS;
                  dd_in    = 64'(dur_ff);
                  dr_in    = '0;
                  dcnt_in  = '0;
                  state_in = cjtg_pkg::ST_AD;
               end
            end
         end
         cjtg_pkg::ST_AD: begin
            if (div_last) begin
               acc_in[jsel_ff] = sat_out(div_q, neg_ff ^ hneg_ff);
               if (jsel_ff == 1'b0 && JOINT_COUNT > 1) begin
                  jsel_in  = 1'b1;
                  state_in = cjtg_pkg::ST_P;
               end else begin
                  state_in = cjtg_pkg::ST_OUT;
               end
            end
         end
         cjtg_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {step_ff, t0_ff + tc_ff, acc_ff[1], acc_ff[0],
                               vel_ff[1], vel_ff[0], ang_ff[1], ang_ff[0]};
               rsp_last_in  = (idx >= ptot_ff);
               pidx_in      = idx;
               if (idx >= ptot_ff) begin
                  moving_in = 1'b0;
               end
               state_in = cjtg_pkg::ST_IDLE;
            end
         end
         default: state_in = cjtg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cjtg_pkg::ST_IDLE;
         iv_ff        <= cjtg_pkg::SAMPLE_INTERVAL_RST;
         rate_ff      <= cjtg_pkg::MAX_JOINT_RATE_RST;
         pidx_ff      <= '0;
         ptot_ff      <= '0;
         moving_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
         jsel_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         iv_ff        <= iv_in;
         rate_ff      <= rate_in;
         pidx_ff      <= pidx_in;
         ptot_ff      <= ptot_in;
         moving_ff    <= moving_in;
         rsp_valid_ff <= rsp_valid_in;
         dcnt_ff      <= dcnt_in;
         jsel_ff      <= jsel_in;
      end
   end

   always_ff @(posedge clock) begin
      sang_ff     <= sang_in;
      dl_ff       <= dl_in;
      dur_ff      <= dur_in;
      t0_ff       <= t0_in;
      tc_ff       <= tc_in;
      step_ff     <= step_in;
      s_ff        <= s_in;
      sq_ff       <= sq_in;
      cu_ff       <= cu_in;
      p_ff        <= p_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      hneg_ff     <= hneg_in;
      tmp_ff      <= tmp_in;
      ang_ff      <= ang_in;
      vel_ff      <= vel_in;
      acc_ff      <= acc_in;
      dq_ff       <= dq_in;
      dr_ff       <= dr_in;
      dd_ff       <= dd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== hdl/cjtg_checker.sv =====
// ----------------------------------------------------------------------------
// cjtg_checker
// Port-level checks of the trajectory generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cjtg_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [255:0] rsp_tdata,
   input logic         rsp_tlast,
   input logic         csr_ready
);

   `CJT_ASSERT_NEXT(a_start_busy, req_tvalid && req_tready && !req_tuser, !req_tready)
   `CJT_ASSERT_IMPL(a_rsp_from_busy, $rose(rsp_tvalid), $past(!req_tready))
   `CJT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `CJT_ASSERT_IMPL(a_csr_open, req_tvalid || !req_tvalid, csr_ready)

endmodule

bind cubic_joint_trajectory_generator cjtg_checker u_cjtg_checker (.*);
